// ===== rtl/rstc_pkg.sv =====
// ----------------------------------------------------------------------------
// Roller shutter controller package
// Shared codes and types for the controller and its serial arithmetic unit.
// ----------------------------------------------------------------------------
package rstc_pkg;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_ACTION = 2'd1;
  localparam logic [1:0] REQ_SETPOS = 2'd2;

  localparam logic [1:0] ACT_OPEN = 2'd0;
  localparam logic [1:0] ACT_CLOSE = 2'd1;
  localparam logic [1:0] ACT_TOGGLE = 2'd2;
  localparam logic [1:0] ACT_STOP = 2'd3;

  localparam logic [1:0] ST_OPENING = 2'd0;
  localparam logic [1:0] ST_CLOSING = 2'd1;
  localparam logic [1:0] ST_STOPPED = 2'd2;

  localparam int REG_INVERT = 4;
  localparam logic [6:0] PCT_FULL = 7'd100;

  // Serial unit operations.
  typedef enum logic [1:0] {
    OP_POSITION = 2'd0,  // elapsed * 100 / full, clamped to 100
    OP_LIMIT = 2'd1      // full * pct / 100
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_ctl_t;

endpackage

// ===== rtl/rstc_arith.sv =====
// ----------------------------------------------------------------------------
// Roller shutter serial arithmetic
// Bit-serial multiply by a 7-bit factor followed by restoring division, one
// bit per cycle. Computes the stop position or the scaled run limit.
// ----------------------------------------------------------------------------
module rstc_arith #(
  parameter int TIME_BITS = 18
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rstc_pkg::arith_ctl_t  ctl,
  input  logic [TIME_BITS-1:0]  a,      // elapsed or full time
  input  logic [TIME_BITS-1:0]  d,      // divisor for the position case
  input  logic [6:0]            factor, // 100 or percent
  output logic                  done,
  output logic [TIME_BITS-1:0]  result
);
  import rstc_pkg::*;

  localparam int PW = TIME_BITS + 7;
  localparam int CW = $clog2(PW + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MUL  = 3'b010,
    S_DIV  = 3'b100
  } state_t;

  state_t               state;
  logic [PW-1:0]        prod;     // product, then dividend shift register
  logic [PW-1:0]        mcand;
  logic [6:0]           mplier;
  logic [TIME_BITS+7:0] rem;
  logic [TIME_BITS-1:0] dvs;
  logic [PW-1:0]        quo;
  logic [CW-1:0]        cnt;
  arith_op_t            op;
  logic [TIME_BITS+7:0] rem_sh;
  logic [TIME_BITS+7:0] rem_sub;

  assign rem_sh  = {rem[TIME_BITS+6:0], prod[PW-1]};
  assign rem_sub = rem_sh - {8'd0, dvs};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (ctl.start) begin
            op     <= ctl.op;
            prod   <= '0;
            mcand  <= {7'd0, a};
            mplier <= factor;
            dvs    <= (ctl.op == OP_LIMIT) ? TIME_BITS'(100) : d;
            cnt    <= '0;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          if (mplier[0]) prod <= prod + mcand;
          mcand  <= {mcand[PW-2:0], 1'b0};
          mplier <= {1'b0, mplier[6:1]};
          if (cnt == CW'(6)) begin
            cnt   <= '0;
            rem   <= '0;
            quo   <= '0;
            state <= S_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DIV: begin
          prod <= {prod[PW-2:0], 1'b0};
          if (!rem_sub[TIME_BITS+7]) begin
            rem <= rem_sub;
            quo <= {quo[PW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[PW-2:0], 1'b0};
          end
          if (cnt == CW'(PW - 1)) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Position clamps to 100; the scaled limit never exceeds the time range.
  always_comb begin
    if (op == OP_POSITION && quo > PW'(100)) result = TIME_BITS'(100);
    else result = quo[TIME_BITS-1:0];
  end

endmodule

// ===== rtl/roller_shutter_timer_controller_top.sv =====
// ----------------------------------------------------------------------------
// Roller shutter timer controller
// Four-channel relay drive with time-based positioning and stop reports.
// ----------------------------------------------------------------------------
// Flow: an action's report is registered in S_SEND, passing S_CALC first when
// a stop of a moving channel computes its position in the bit-serial divider.
// A set-position item runs the divider from S_LIMIT. A tick scans one channel
// per cycle while no report waits, plus a divider pass per stop report.
// One item at a time; reset stops all channels and clears timers, limits, config.
module roller_shutter_timer_controller_top #(
  parameter int CHANNELS  = 4,
  parameter int TIME_BITS = 18
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // req_type[1:0], channel[3:2], action[5:4], percent[12:6]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // report_channel[1:0], motion_state[3:2], drive_image[11:4],
                                      // position[18:12], position_valid[19]
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import rstc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_CALC  = 5'b00100,
    S_SEND  = 5'b01000,
    S_LIMIT = 5'b10000
  } state_t;

  localparam logic [TIME_BITS-1:0] TMAX = '1;

  logic [TIME_BITS-1:0] full_time [4];
  logic [3:0]           invert_mask;
  logic [3:0]           moving;
  logic [TIME_BITS-1:0] elapsed [4];
  logic [TIME_BITS-1:0] run_limit [4];
  logic [3:0]           last_was_close;
  logic [7:0]           relay_bits;

  state_t     state;
  logic [1:0] ch;
  logic [1:0] scan_ch;
  logic       from_tick;
  logic [1:0] o_ch;
  logic [1:0] o_st;
  logic [6:0] o_pos;
  logic       o_valid;
  logic       o_last;

  arith_ctl_t           actl;
  logic [TIME_BITS-1:0] a_a;
  logic [TIME_BITS-1:0] a_d;
  logic [6:0]           a_f;
  logic                 a_done;
  logic [TIME_BITS-1:0] a_res;

  logic [1:0] in_req, in_ch, in_act;
  logic [6:0] in_pct;
  assign in_req = s_axis_tdata[1:0];
  assign in_ch  = s_axis_tdata[3:2];
  assign in_act = s_axis_tdata[5:4];
  assign in_pct = s_axis_tdata[12:6];

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign cfg_ready     = 1'b1;

  assign m_axis_tdata = {4'd0, o_valid, o_pos, relay_bits, o_st, o_ch};
  assign m_axis_tlast = o_last;

  rstc_arith #(.TIME_BITS(TIME_BITS)) u_arith (
    .clk(clk), .rst(rst), .ctl(actl), .a(a_a), .d(a_d), .factor(a_f),
    .done(a_done), .result(a_res)
  );

  // Elapsed after this tick's increment for the scanned channel.
  logic [TIME_BITS-1:0] el_inc;
  assign el_inc = (elapsed[scan_ch] < TMAX) ? elapsed[scan_ch] + 1'b1 : elapsed[scan_ch];

  // Any moving channel above the scanned one that will stop this tick.
  logic later_stop;
  always_comb begin
    later_stop = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (i > int'(scan_ch) && i < CHANNELS && moving[i]) begin
        if (((elapsed[i] < TMAX) ? elapsed[i] + 1'b1 : elapsed[i]) >= run_limit[i])
          later_stop = 1'b1;
      end
    end
  end

  logic inv;
  assign inv = invert_mask[in_ch];

  always_ff @(posedge clk) begin
    actl.start <= 1'b0;
    if (rst) begin
      state          <= S_IDLE;
      m_axis_tvalid  <= 1'b0;
      moving         <= '0;
      last_was_close <= '1;
      relay_bits     <= '0;
      invert_mask    <= '0;
      actl.op        <= OP_POSITION;
      for (int i = 0; i < 4; i++) begin
        full_time[i] <= '0;
        elapsed[i]   <= '0;
        run_limit[i] <= '0;
      end
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (cfg_valid) begin
        if (cfg_index < 3'(REG_INVERT)) full_time[cfg_index[1:0]] <= cfg_data[TIME_BITS-1:0];
        else if (cfg_index == 3'(REG_INVERT)) invert_mask <= cfg_data[3:0];
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            ch <= in_ch;
            if (in_req == REQ_TICK) begin
              scan_ch <= '0;
              state   <= S_SCAN;
            end else if (int'(in_ch) < CHANNELS && in_req == REQ_ACTION) begin
              logic [1:0] act;
              act = in_act;
              run_limit[in_ch] <= full_time[in_ch];
              if (act == ACT_TOGGLE)
                act = moving[in_ch] ? ACT_STOP : (last_was_close[in_ch] ? ACT_OPEN : ACT_CLOSE);
              o_ch    <= in_ch;
              o_last  <= 1'b1;
              o_pos   <= '0;
              from_tick <= 1'b0;
              if (act == ACT_OPEN || act == ACT_CLOSE) begin
                last_was_close[in_ch]   <= (act == ACT_CLOSE);
                relay_bits[{in_ch, 1'b0}] <= (act == ACT_CLOSE) ^ inv;
                relay_bits[{in_ch, 1'b1}] <= (act != ACT_CLOSE) ^ inv;
                moving[in_ch]  <= 1'b1;
                elapsed[in_ch] <= '0;
                o_valid <= 1'b0;
                o_st  <= (act == ACT_CLOSE) ? ST_CLOSING : ST_OPENING;
                state <= S_SEND;
              end else begin
                relay_bits[{in_ch, 1'b0}] <= 1'b0;
                relay_bits[{in_ch, 1'b1}] <= 1'b0;
                o_st <= ST_STOPPED;
                // Only a stop of a moving channel carries a position.
                o_valid <= moving[in_ch];
                if (moving[in_ch]) begin
                  a_a        <= elapsed[in_ch];
                  a_d        <= full_time[in_ch];
                  a_f        <= PCT_FULL;
                  actl.op    <= OP_POSITION;
                  actl.start <= 1'b1;
                  state      <= S_CALC;
                end else begin
                  state <= S_SEND;
                end
                moving[in_ch]  <= 1'b0;
                elapsed[in_ch] <= '0;
              end
            end else if (int'(in_ch) < CHANNELS && in_req == REQ_SETPOS) begin
              a_a        <= full_time[in_ch];
              a_d        <= full_time[in_ch];
              a_f        <= (in_pct > PCT_FULL) ? PCT_FULL : in_pct;
              actl.op    <= OP_LIMIT;
              actl.start <= 1'b1;
              state      <= S_LIMIT;
            end
          end
        end
        S_SCAN: begin
          if (!m_axis_tvalid) begin
            if (int'(scan_ch) < CHANNELS && moving[scan_ch]) begin
              if (el_inc >= run_limit[scan_ch]) begin
                relay_bits[{scan_ch, 1'b0}] <= 1'b0;
                relay_bits[{scan_ch, 1'b1}] <= 1'b0;
                moving[scan_ch]  <= 1'b0;
                elapsed[scan_ch] <= '0;
                o_ch      <= scan_ch;
                o_st      <= ST_STOPPED;
                o_valid   <= 1'b1;
                o_last    <= !later_stop;
                from_tick <= 1'b1;
                a_a        <= el_inc;
                a_d        <= full_time[scan_ch];
                a_f        <= PCT_FULL;
                actl.op    <= OP_POSITION;
                actl.start <= 1'b1;
                state      <= S_CALC;
              end else begin
                elapsed[scan_ch] <= el_inc;
              end
            end
            if (state == S_SCAN && !(int'(scan_ch) < CHANNELS && moving[scan_ch]
                && el_inc >= run_limit[scan_ch])) begin
              if (scan_ch == 2'd3) state <= S_IDLE;
              scan_ch <= scan_ch + 1'b1;
            end
          end
        end
        S_CALC: begin
          if (a_done) begin
            o_pos <= (a_d == '0) ? PCT_FULL : a_res[6:0];
            state <= S_SEND;
          end
        end
        S_SEND: begin
          m_axis_tvalid <= 1'b1;
          if (from_tick && scan_ch != 2'd3) begin
            scan_ch <= scan_ch + 1'b1;
            state   <= S_SCAN;
          end else begin
            state <= S_IDLE;
          end
        end
        S_LIMIT: begin
          if (a_done) begin
            run_limit[ch] <= a_res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
